/* sv/lj_pair_potential_virial_defines.svh */
// assertion helpers shared by the rtl
`ifndef LJ_PAIR_POTENTIAL_VIRIAL_DEFINES_SVH
`define LJ_PAIR_POTENTIAL_VIRIAL_DEFINES_SVH

// same-cycle implication, masked while in reset
`define LJPV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ljpv: implication check failed");

// next-cycle implication, active through reset
`define LJPV_ASSERT_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ljpv: next-cycle check failed");

`endif

/* sv/ljpv_pkg.sv */
`timescale 1ns / 1ps
package ljpv_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BOX_X   = 3'd0,
    REG_BOX_Y   = 3'd1,
    REG_BOX_Z   = 3'd2,
    REG_CUTOFF  = 3'd3,
    REG_OVERLAP = 3'd4
  } ljpv_reg_t;

  // per-item flags carried down the pipeline
  typedef struct packed {
    logic ovl;
    logic in_cut;
    logic sat;
  } ljpv_ctl_t;

  localparam int SR2_W       = 26;
  localparam int DIV_STEP    = 2;
  localparam int DIV_STAGES  = SR2_W / DIV_STEP;
  localparam int AXIS_STAGES = 3;
  localparam int TOP_STAGES  = 3;
  localparam int POW_STAGES  = 4;
  localparam int LATENCY     = AXIS_STAGES + TOP_STAGES + DIV_STAGES + POW_STAGES;

  // 2^72 with the low quotient bits stripped off
  localparam logic [63:0] DIV_INIT_REM = 64'h0000_4000_0000_0000;
  // below this r the reciprocal is at least 3.0 and both outputs saturate
  localparam logic [63:0] SAT_SR2_R    = 64'd93824992236885;
  // 2^40: bound on the upper part of r * overlap_limit
  localparam logic [64:0] OVL_BOUND    = 65'h000_0100_0000_0000;

  localparam logic [23:0] BOX_RESET     = 24'd655360;
  localparam logic [23:0] CUTOFF_RESET  = 24'd163840;
  localparam logic [31:0] OVERLAP_RESET = 32'd29826162;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // clamp to signed 32 bit
  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] res;
    if (v > 41'sd2147483647) res = Q_MAX;
    else if (v < -41'sd2147483648) res = Q_MIN;
    else res = v[31:0];
    return res;
  endfunction

endpackage

/* sv/ljpv_axis.sv */
`timescale 1ns / 1ps
module ljpv_axis (
  input  logic               clk,
  input  logic signed [23:0] a,
  input  logic signed [23:0] b,
  input  logic        [23:0] box,
  output logic        [63:0] sq
);
  import ljpv_pkg::*;

  logic signed [24:0] diff;
  logic        [24:0] mag;
  logic        [25:0] rnd;
  logic        [1:0]  wraps;
  logic signed [25:0] folded;
  logic        [22:0] um;
  logic        [47:0] prod;
  logic        [31:0] s;

  // stage 1: difference and minimum image fold
  always_comb begin
    diff   = 25'(a) - 25'(b);
    mag    = diff[24] ? 25'(-diff) : 25'(diff);
    rnd    = {1'b0, mag} + 26'h040_0000;
    wraps  = rnd[24:23];
    folded = $signed({1'b0, mag}) - $signed({1'b0, wraps, 23'b0});
  end

  always_ff @(posedge clk) begin
    um <= folded[25] ? 23'(-folded) : 23'(folded);
  end

  // stage 2: scale by box length, round to 2^-24
  always_ff @(posedge clk) begin
    prod <= {1'b0, 47'(um * box)} + 48'h4000;
  end

  always_comb s = prod[46:15];

  // stage 3: square
  always_ff @(posedge clk) begin
    sq <= s * s;
  end

endmodule

/* sv/ljpv_recip.sv */
`timescale 1ns / 1ps
module ljpv_recip (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [63:0]              r_in,
  input  ljpv_pkg::ljpv_ctl_t      ctl_in,
  output logic                     out_valid,
  output logic [ljpv_pkg::SR2_W-1:0] sr2,
  output ljpv_pkg::ljpv_ctl_t      ctl_out
);
  import ljpv_pkg::*;

  logic [63:0]      rem [0:DIV_STAGES];
  logic [63:0]      dvs [0:DIV_STAGES];
  logic [SR2_W-1:0] quo [0:DIV_STAGES];
  ljpv_ctl_t        ctl [0:DIV_STAGES];
  logic             vld [0:DIV_STAGES];

  assign rem[0] = DIV_INIT_REM;
  assign dvs[0] = r_in;
  assign quo[0] = '0;
  assign ctl[0] = ctl_in;
  assign vld[0] = in_valid;

  // restoring division of 2^72 by r, two quotient bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [63:0]      step_rem;
    logic [SR2_W-1:0] step_quo;

    always_comb begin
      logic [64:0] trial;
      step_rem = rem[g];
      step_quo = quo[g];
      for (int k = 0; k < DIV_STEP; k++) begin
        trial = {step_rem, 1'b0};
        if (trial >= {1'b0, dvs[g]}) begin
          step_rem = 64'(trial - {1'b0, dvs[g]});
          step_quo = {step_quo[SR2_W-2:0], 1'b1};
        end else begin
          step_rem = trial[63:0];
          step_quo = {step_quo[SR2_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem[g+1] <= step_rem;
      quo[g+1] <= step_quo;
      dvs[g+1] <= dvs[g];
      ctl[g+1] <= ctl[g];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign sr2       = quo[DIV_STAGES];
  assign ctl_out   = ctl[DIV_STAGES];

endmodule

/* sv/ljpv_powers.sv */
`timescale 1ns / 1ps
module ljpv_powers (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ljpv_pkg::SR2_W-1:0] sr2_in,
  input  ljpv_pkg::ljpv_ctl_t        ctl_in,
  output logic                       out_valid,
  output logic signed [31:0]         pot,
  output logic signed [31:0]         vir,
  output logic                       flag
);
  import ljpv_pkg::*;

  logic [SR2_W-1:0] sr2_a;
  logic [27:0]      sr4;
  logic [29:0]      sr6_b, sr6_c;
  logic [35:0]      sr12;
  ljpv_ctl_t        ctl_a, ctl_b, ctl_c;
  logic             v_a, v_b, v_c;
  logic [51:0]      p4;
  logic [53:0]      p6;
  logic [59:0]      p12;
  logic signed [40:0] pot_raw, vir_raw;

  always_comb begin
    p4  = sr2_in * sr2_in;
    p6  = sr4 * sr2_a;
    p12 = sr6_b * sr6_b;
  end

  // sr4, sr6, sr12 each in a stage of their own
  always_ff @(posedge clk) begin
    sr4   <= p4[51:24];
    sr2_a <= sr2_in;
    ctl_a <= ctl_in;
    sr6_b <= p6[53:24];
    ctl_b <= ctl_a;
    sr12  <= p12[59:24];
    sr6_c <= sr6_b;
    ctl_c <= ctl_b;
  end

  always_comb begin
    pot_raw = $signed({5'b0, sr12}) - $signed({11'b0, sr6_c});
    vir_raw = $signed({3'b0, sr12, 2'b0}) - $signed({10'b0, sr6_c, 1'b0});
  end

  // special cases and saturation into the output register
  always_ff @(posedge clk) begin
    flag <= ctl_c.ovl;
    if (ctl_c.ovl || !ctl_c.in_cut) begin
      pot <= '0;
      vir <= '0;
    end else if (ctl_c.sat) begin
      pot <= Q_MAX;
      vir <= Q_MAX;
    end else begin
      pot <= sat32(pot_raw);
      vir <= sat32(vir_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_a       <= in_valid;
      v_b       <= v_a;
      v_c       <= v_b;
      out_valid <= v_c;
    end
  end

endmodule

/* sv/lj_pair_potential_virial.sv */
`timescale 1ns / 1ps
`include "lj_pair_potential_virial_defines.svh"
// Lennard-Jones pair energy and virial with periodic minimum image. One pair
// is taken on every clock where start is high; busy stays low, so the block
// never refuses an item. Each result appears for a single cycle with
// result_valid high and must be captured then: there is no way to hold it.
// The pipeline has three stages per axis (fold, scale, square), three for
// the sum and overlap test, thirteen for the reciprocal divider at two
// quotient bits per stage, and four for the powers and output register.
// Registers are written through cfg_valid/cfg_ready (ready is always high);
// the user must write them only while no item is in flight, which the block
// does not enforce. The squared cutoff is registered from the cutoff register.
module lj_pair_potential_virial #(
  parameter int DIMENSIONS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] first_x,
  input  logic signed [23:0] first_y,
  input  logic signed [23:0] first_z,
  input  logic signed [23:0] second_x,
  input  logic signed [23:0] second_y,
  input  logic signed [23:0] second_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               result_valid,
  output logic signed [31:0] pair_potential,
  output logic signed [31:0] pair_virial,
  output logic               overlap_flag
);
  import ljpv_pkg::*;

  logic [23:0] box_x, box_y, box_z, cutoff;
  logic [31:0] ovl_limit;
  logic [47:0] rc2;

  logic [63:0] sq_x, sq_y, sq_z;
  logic [63:0] r_sum, r_chk;
  logic [63:0] prod_lo, prod_hi;
  logic        r_zero, in_cut_a, sat_a;
  logic [64:0] hi_sum;
  ljpv_ctl_t   ctl_top;
  logic [AXIS_STAGES+TOP_STAGES-1:0] vpipe;

  logic             div_valid;
  logic [SR2_W-1:0] sr2;
  ljpv_ctl_t        ctl_div;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x     <= BOX_RESET;
      box_y     <= BOX_RESET;
      box_z     <= BOX_RESET;
      cutoff    <= CUTOFF_RESET;
      ovl_limit <= OVERLAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOX_X:   box_x     <= cfg_data[23:0];
        REG_BOX_Y:   box_y     <= cfg_data[23:0];
        REG_BOX_Z:   box_z     <= cfg_data[23:0];
        REG_CUTOFF:  cutoff    <= cfg_data[23:0];
        REG_OVERLAP: ovl_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared cutoff, held from the register
  always_ff @(posedge clk) begin
    rc2 <= cutoff * cutoff;
  end

  // per-axis squared distance
  ljpv_axis u_axis_x (.clk(clk), .a(first_x), .b(second_x), .box(box_x), .sq(sq_x));
  ljpv_axis u_axis_y (.clk(clk), .a(first_y), .b(second_y), .box(box_y), .sq(sq_y));

  if (DIMENSIONS >= 3) begin : g_z
    ljpv_axis u_axis_z (.clk(clk), .a(first_z), .b(second_z), .box(box_z), .sq(sq_z));
  end else begin : g_no_z
    assign sq_z = '0;
  end

  // item valid through axis and top stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[AXIS_STAGES+TOP_STAGES-2:0], start && !busy};
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    r_sum <= sq_x + sq_y + sq_z;
  end

  // partial products of r * limit, cutoff and saturation tests
  always_ff @(posedge clk) begin
    prod_lo  <= r_sum[31:0] * ovl_limit;
    prod_hi  <= r_sum[63:32] * ovl_limit;
    r_chk    <= r_sum;
    r_zero   <= (r_sum == 64'd0);
    in_cut_a <= (r_sum < {rc2, 16'b0});
    sat_a    <= (r_sum <= SAT_SR2_R);
  end

  // overlap when 1/r exceeds the limit
  assign hi_sum = {1'b0, prod_hi} + {33'b0, prod_lo[63:32]};

  logic [63:0] r_div;
  always_ff @(posedge clk) begin
    r_div          <= r_chk;
    ctl_top.ovl    <= r_zero || (hi_sum < OVL_BOUND);
    ctl_top.in_cut <= in_cut_a;
    ctl_top.sat    <= sat_a;
  end

  ljpv_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vpipe[AXIS_STAGES+TOP_STAGES-1]),
    .r_in     (r_div),
    .ctl_in   (ctl_top),
    .out_valid(div_valid),
    .sr2      (sr2),
    .ctl_out  (ctl_div)
  );

  ljpv_powers u_powers (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .sr2_in   (sr2),
    .ctl_in   (ctl_div),
    .out_valid(result_valid),
    .pot      (pair_potential),
    .vir      (pair_virial),
    .flag     (overlap_flag)
  );

  // checks
  `LJPV_ASSERT_NXT(a_reset_quiet, clk, rst, !result_valid)
  `LJPV_ASSERT_IMP(a_latency, clk, rst, start && !busy, ##LATENCY result_valid)
  `LJPV_ASSERT_IMP(a_ovl_zero, clk, rst, result_valid && overlap_flag, pair_potential == 32'sd0 && pair_virial == 32'sd0)

endmodule
